@@ hw/rtl/bmrq_pkg.sv @@
// Shared types and codes for the bounded multiset with rank query unit.
package bmrq_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_RANK   = 2'd3
  } action_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_EMPTIED = 3'd4;

  localparam logic [1:0] POL_REFUSE = 2'd1;
  localparam logic [1:0] POL_DROP   = 2'd2;

  localparam logic REG_DUP_POLICY    = 1'b0;
  localparam logic REG_EMPTY_ALLOWED = 1'b1;

  typedef struct packed {
    logic       load;
    logic       scan;
    logic       rank_rd;
    logic       rank_cap;
    logic       ins_init;
    logic       ins_rd;
    logic       ins_wr;
    logic       ins_put;
    logic       rem_init;
    logic       rem_rd;
    logic       rem_wr;
    logic       rem_fin;
    logic       set_st;
    logic [2:0] st_code;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic       scan_done;
    logic       found;
    logic       full;
    logic       ins_more;
    logic       rem_more;
    logic       out_free;
    action_t    act;
    logic [1:0] pol;
  } sts_t;

endpackage

@@ hw/rtl/bmrq_ram.sv @@
// Generic simple dual-port RAM with registered read.
module bmrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/bmrq_ctrl.sv @@
// Controller state machine for the multiset unit.
module bmrq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      action,
  output logic            in_stall,
  input  bmrq_pkg::sts_t  sts,
  output bmrq_pkg::cmd_t  cmd
);
  import bmrq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RANK_RD, S_RANK_CAP, S_SCAN, S_DECIDE,
    S_INS_RD, S_INS_WR, S_REM_RD, S_REM_WR, S_DONE
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (action_t'(action) == ACT_RANK) ? S_RANK_RD : S_SCAN;
        end
      end
      S_RANK_RD: begin
        cmd.rank_rd = 1'b1;
        state_next  = S_RANK_CAP;
      end
      S_RANK_CAP: begin
        cmd.rank_cap = 1'b1;
        state_next   = S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_DONE;
        if (sts.act == ACT_ADD) begin
          if (sts.found && sts.pol == POL_REFUSE) begin
            cmd.set_st  = 1'b1;
            cmd.st_code = ST_DUP;
          end else if (sts.found && sts.pol == POL_DROP) begin
            cmd.set_st = 1'b0;
          end else if (sts.full) begin
            cmd.set_st  = 1'b1;
            cmd.st_code = ST_FULL;
          end else begin
            cmd.ins_init = 1'b1;
            state_next   = S_INS_RD;
          end
        end else if (sts.act == ACT_REMOVE && sts.found) begin
          cmd.rem_init = 1'b1;
          state_next   = S_REM_RD;
        end
      end
      S_INS_RD: begin
        if (sts.ins_more) begin
          cmd.ins_rd = 1'b1;
          state_next = S_INS_WR;
        end else begin
          cmd.ins_put = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_next = S_INS_RD;
      end
      S_REM_RD: begin
        if (sts.rem_more) begin
          cmd.rem_rd = 1'b1;
          state_next = S_REM_WR;
        end else begin
          cmd.rem_fin = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_REM_WR: begin
        cmd.rem_wr = 1'b1;
        state_next = S_REM_RD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

@@ hw/rtl/bmrq_dp.sv @@
// Datapath: entry RAM, scan counters, shift engine, config and result registers.
module bmrq_dp #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32,
  parameter int CW         = $clog2(CAPACITY + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [1:0]      cfg_wdata,
  input  logic [1:0]      action,
  input  logic [31:0]     number,
  input  logic [5:0]      rank,
  input  bmrq_pkg::cmd_t  cmd,
  output bmrq_pkg::sts_t  sts,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            found,
  output logic [CW-1:0]   occurrences,
  output logic [31:0]     rank_value,
  output logic [CW-1:0]   element_count,
  output logic [2:0]      status
);
  import bmrq_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int DW  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int RKW = (CW > 6) ? CW : 6;

  logic [1:0]    dup_policy;
  logic          empty_allowed;
  action_t       act;
  logic [DW-1:0] num;
  logic [RKW-1:0] rank_ext;
  logic [CW-1:0] count, idx, lt, eq, occ;
  logic          pend;
  logic [2:0]    st;
  logic [31:0]   rval;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic [CW-1:0] pos, idx_inc, idx_dec;
  logic          scan_more, in_range;

  assign pos       = lt + eq;
  assign idx_inc   = idx + CW'(1);
  assign idx_dec   = idx - CW'(1);
  assign scan_more = idx < count;
  assign in_range  = rank_ext < RKW'(count);

  always_comb begin
    raddr = idx[AW-1:0];
    if (cmd.rank_rd)     raddr = rank_ext[AW-1:0];
    else if (cmd.ins_rd) raddr = idx_dec[AW-1:0];
    else if (cmd.rem_rd) raddr = idx_inc[AW-1:0];
    we    = cmd.ins_wr | cmd.ins_put | cmd.rem_wr;
    waddr = cmd.ins_put ? pos[AW-1:0] : idx[AW-1:0];
    wdata = cmd.ins_put ? num : rdata;
  end

  bmrq_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sts.scan_done = !scan_more && !pend;
    sts.found     = (eq != '0);
    sts.full      = (count >= CW'(CAPACITY));
    sts.ins_more  = idx > pos;
    sts.rem_more  = idx_inc < count;
    sts.out_free  = !out_valid || !out_stall;
    sts.act       = act;
    sts.pol       = dup_policy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dup_policy    <= '0;
      empty_allowed <= 1'b1;
      count         <= '0;
      out_valid     <= 1'b0;
      pend          <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DUP_POLICY) dup_policy <= cfg_wdata;
        else                             empty_allowed <= cfg_wdata[0];
      end
      if (cmd.finish)                   out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      if (cmd.load) begin
        act      <= action_t'(action);
        num      <= number[DW-1:0];
        rank_ext <= RKW'(rank);
        idx      <= '0;
        lt       <= '0;
        eq       <= '0;
        occ      <= '0;
        pend     <= 1'b0;
        st       <= ST_OK;
        rval     <= '0;
      end
      // pipelined scan: address issued, then the read data compared in the next cycle
      if (cmd.scan) begin
        pend <= scan_more;
        if (scan_more) idx <= idx_inc;
        if (pend) begin
          if (rdata < num) lt <= lt + CW'(1);
          if (rdata == num) begin
            eq  <= eq + CW'(1);
            occ <= occ + CW'(1);
          end
        end
      end
      if (cmd.rank_cap) begin
        if (in_range) rval <= 32'(rdata);
        else          st   <= ST_RANGE;
      end
      if (cmd.set_st)   st  <= cmd.st_code;
      if (cmd.ins_init) idx <= count;
      if (cmd.ins_wr)   idx <= idx_dec;
      if (cmd.ins_put) begin
        count <= count + CW'(1);
        occ   <= occ + CW'(1);
      end
      if (cmd.rem_init) idx <= lt;
      if (cmd.rem_wr)   idx <= idx_inc;
      if (cmd.rem_fin) begin
        count <= count - CW'(1);
        occ   <= occ - CW'(1);
        if (count == CW'(1) && !empty_allowed) st <= ST_EMPTIED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found         <= (act != ACT_RANK) && (eq != '0);
      occurrences   <= (act == ACT_RANK) ? '0 : occ;
      rank_value    <= rval;
      element_count <= count;
      status        <= st;
    end
  end
endmodule

@@ hw/rtl/bounded_multiset_with_rank_query_unit.sv @@
// Top level of the bounded sorted multiset with rank query.
//
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_stall   | action, number, rank
//  out     | out       | out_valid/out_stall | found, occurrences, rank_value,
//          |           |                     | element_count, status
//  cfg     | in        | cfg_we              | cfg_index, cfg_wdata
//
// A rank read addresses the RAM at the rank directly. A query or refused add
// scans the set with one RAM read per entry scanned. An add or remove that
// changes the set also shifts each entry above its position, read then write.
// Synchronous reset empties the set; no clearing pass is needed.
// A result waiting on out_stall does not stop the next transaction being taken;
// that transaction then waits in the last state until the old result has gone.
module bounded_multiset_with_rank_query_unit #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [1:0]                      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      action,
  input  logic [31:0]                     number,
  input  logic [5:0]                      rank,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [$clog2(CAPACITY+1)-1:0]   occurrences,
  output logic [31:0]                     rank_value,
  output logic [$clog2(CAPACITY+1)-1:0]   element_count,
  output logic [2:0]                      status
);
  import bmrq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bmrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bmrq_dp #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .action        (action),
    .number        (number),
    .rank          (rank),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .occurrences   (occurrences),
    .rank_value    (rank_value),
    .element_count (element_count),
    .status        (status)
  );
endmodule
